[sv/rctc_pkg.sv]
// ----------------------------------------------------------------------------
// rctc_pkg
// Types, codes and display tables for the relay countdown timer controller.
// ----------------------------------------------------------------------------
package rctc_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int KEY_W       = 4;
  localparam int SEC_W       = 12;
  localparam int CNT_W       = 16;
  localparam int SEG_W       = 7;
  localparam int CFG_IDX_W   = 1;

  localparam logic [KEY_W-1:0] KEY_NONE   = KEY_W'(0);
  localparam logic [KEY_W-1:0] KEY_MANUAL = KEY_W'(NUM_BUTTONS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_SECOND = 1'b0,
    CFG_SPLASH_TICKS     = 1'b1
  } cfg_idx_t;

  localparam logic [CNT_W-1:0] TICKS_PER_SECOND_RST = 16'd1000;
  localparam logic [CNT_W-1:0] SPLASH_TICKS_RST     = 16'd3000;

  // minutes = ((seconds + 59) * 2185) >> 17, exact for seconds up to 3600
  localparam logic [SEC_W-1:0] MIN_ROUND  = 12'd59;
  localparam logic [SEC_W-1:0] MIN_RECIP  = 12'd2185;
  localparam int               MIN_SHIFT  = 17;
  localparam int               MIN_W      = 6;

  localparam logic [SEG_W-1:0] SEG_DARK  = 7'h00;
  localparam logic [SEG_W-1:0] SEG_O     = 7'h3F;
  localparam logic [SEG_W-1:0] SEG_N     = 7'h54;
  localparam logic [SEG_W-1:0] SEG_F     = 7'h71;

  typedef struct packed {
    logic [SEG_W-1:0] right;
    logic [SEG_W-1:0] middle;
    logic [SEG_W-1:0] left;
  } seg_disp_t;

  localparam seg_disp_t PAT_ON   = '{right: SEG_DARK, middle: SEG_N, left: SEG_O};
  localparam seg_disp_t PAT_OFF  = '{right: SEG_F, middle: SEG_F, left: SEG_O};
  localparam seg_disp_t PAT_ZERO = '{right: SEG_O, middle: SEG_O, left: SEG_O};

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_DARK;
    endcase
    return s;
  endfunction

  // Three digit pattern for a minute count below 64 (hundreds always 0).
  function automatic seg_disp_t minutes_pattern(input logic [MIN_W-1:0] q);
    logic [3:0]       tens;
    logic [MIN_W-1:0] base;
    logic [MIN_W-1:0] ones;
    seg_disp_t        p;
    priority if (q >= 6'd60) begin
      tens = 4'd6; base = 6'd60;
    end else if (q >= 6'd50) begin
      tens = 4'd5; base = 6'd50;
    end else if (q >= 6'd40) begin
      tens = 4'd4; base = 6'd40;
    end else if (q >= 6'd30) begin
      tens = 4'd3; base = 6'd30;
    end else if (q >= 6'd20) begin
      tens = 4'd2; base = 6'd20;
    end else if (q >= 6'd10) begin
      tens = 4'd1; base = 6'd10;
    end else begin
      tens = 4'd0; base = 6'd0;
    end
    ones     = q - base;
    p.left   = digit_seg(4'd0);
    p.middle = digit_seg(tens);
    p.right  = digit_seg(ones[3:0]);
    return p;
  endfunction

  // Preset countdown in seconds for keys 1 to 9; other keys load zero.
  function automatic logic [SEC_W-1:0] preset_seconds(input logic [KEY_W-1:0] key);
    logic [SEC_W-1:0] s;
    unique case (key)
      4'd1:    s = 12'd300;
      4'd2:    s = 12'd600;
      4'd3:    s = 12'd900;
      4'd4:    s = 12'd1200;
      4'd5:    s = 12'd1800;
      4'd6:    s = 12'd2400;
      4'd7:    s = 12'd2700;
      4'd8:    s = 12'd3000;
      4'd9:    s = 12'd3600;
      default: s = 12'd0;
    endcase
    return s;
  endfunction

endpackage

[sv/relay_countdown_timer_controller_core.sv]
// ----------------------------------------------------------------------------
// relay_countdown_timer_controller_core
// Millisecond-tick relay timer: key presets, manual mode, 3-digit display.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, sustained while the output side is ready.
// Each item is one millisecond tick with a button sample and yields exactly
// one result item: the accepting edge loads the input register, and when the
// output side is ready the combinational state update moves it into the
// result register. The state update (tick counter, countdown, key edge pick,
// minute display) is one combinational pass, which sets that rate.
// Configuration writes are taken at any time and are meant to be issued
// only while the block is idle.
module relay_countdown_timer_controller_core
  import rctc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUM_BUTTONS-1:0] in_buttons,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_relay_on,
  output logic [SEG_W-1:0]       out_seg_left,
  output logic [SEG_W-1:0]       out_seg_middle,
  output logic [SEG_W-1:0]       out_seg_right,
  output logic                   out_manual_active,
  output logic [KEY_W-1:0]       out_key_taken,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  // pipeline control
  logic                   s1_valid_r;
  logic [NUM_BUTTONS-1:0] s1_buttons_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_fire;
  logic                   cfg_fire;

  // configuration
  logic [CNT_W-1:0]       tps_r;

  // timer state
  logic [CNT_W-1:0]       tick_r,   tick_nxt;
  logic [SEC_W-1:0]       sec_r,    sec_nxt;
  logic                   relay_r,  relay_nxt;
  logic                   manual_r, manual_nxt;
  logic [NUM_BUTTONS-1:0] held_r,   held_nxt;
  seg_disp_t              shown_r,  shown_nxt;
  logic [CNT_W-1:0]       splash_r, splash_nxt;
  logic [KEY_W-1:0]       key_nxt;

  // result register
  logic                   res_relay_r;
  seg_disp_t              res_shown_r;
  logic                   res_manual_r;
  logic [KEY_W-1:0]       res_key_r;

  // datapath temporaries
  logic [CNT_W:0]         tick_inc;
  logic                   sec_wrap;
  logic [SEC_W-1:0]       sec_dec;
  logic [NUM_BUTTONS-1:0] edges;
  logic [NUM_BUTTONS-1:0] pick;
  logic [SEC_W-1:0]       min_x;
  logic [2*SEC_W-1:0]     min_prod;
  logic [MIN_W-1:0]       minutes;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_valid         = out_valid_r;
  assign out_relay_on      = res_relay_r;
  assign out_seg_left      = res_shown_r.left;
  assign out_seg_middle    = res_shown_r.middle;
  assign out_seg_right     = res_shown_r.right;
  assign out_manual_active = res_manual_r;
  assign out_key_taken     = res_key_r;

  always_comb begin
    tick_nxt   = tick_r;
    sec_nxt    = sec_r;
    relay_nxt  = relay_r;
    manual_nxt = manual_r;
    held_nxt   = held_r;
    shown_nxt  = shown_r;
    splash_nxt = splash_r;
    key_nxt    = KEY_NONE;
    edges      = '0;
    pick       = '0;
    min_x      = '0;
    min_prod   = '0;
    minutes    = '0;

    // tick counter and seconds
    tick_inc = {1'b0, tick_r} + (CNT_W+1)'(1);
    sec_wrap = tick_inc >= {1'b0, tps_r};
    sec_dec  = (sec_r != '0) ? sec_r - SEC_W'(1) : sec_r;
    tick_nxt = sec_wrap ? '0 : tick_inc[CNT_W-1:0];
    sec_nxt  = sec_wrap ? sec_dec : sec_r;

    if (splash_r != '0) begin
      splash_nxt = splash_r - CNT_W'(1);
      held_nxt   = s1_buttons_r;
      if (splash_nxt == '0) begin
        shown_nxt = PAT_ZERO;
      end
    end else begin
      // lowest new press
      edges = s1_buttons_r & ~held_r;
      pick  = edges & (~edges + NUM_BUTTONS'(1));
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (pick[i]) begin
          key_nxt = KEY_W'(i + 1);
        end
      end
      held_nxt = (held_r | pick) & s1_buttons_r;

      if (key_nxt == KEY_MANUAL) begin
        sec_nxt = '0;
        if (relay_r) begin
          relay_nxt  = 1'b0;
          manual_nxt = 1'b0;
          shown_nxt  = PAT_OFF;
        end else begin
          relay_nxt  = 1'b1;
          manual_nxt = 1'b1;
          shown_nxt  = PAT_ON;
        end
      end else if (key_nxt != KEY_NONE) begin
        manual_nxt = 1'b0;
        sec_nxt    = preset_seconds(key_nxt);
        relay_nxt  = 1'b1;
      end

      // remaining minutes, rounded up
      min_x    = sec_nxt + MIN_ROUND;
      min_prod = min_x * MIN_RECIP;
      minutes  = min_prod[MIN_SHIFT +: MIN_W];

      if (sec_nxt != '0 && !manual_nxt) begin
        shown_nxt = minutes_pattern(minutes);
      end else if (relay_nxt && !manual_nxt && sec_nxt == '0) begin
        relay_nxt = 1'b0;
        shown_nxt = PAT_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tps_r       <= TICKS_PER_SECOND_RST;
      tick_r      <= '0;
      sec_r       <= '0;
      relay_r     <= 1'b0;
      manual_r    <= 1'b0;
      held_r      <= '0;
      shown_r     <= PAT_ON;
      splash_r    <= SPLASH_TICKS_RST;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_fire) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TICKS_PER_SECOND: tps_r <= cfg_wdata;
          CFG_SPLASH_TICKS: begin
            splash_r <= cfg_wdata;
            shown_r  <= (cfg_wdata != '0) ? PAT_ON : PAT_ZERO;
          end
          default: tps_r <= tps_r;
        endcase
      end else if (advance) begin
        tick_r   <= tick_nxt;
        sec_r    <= sec_nxt;
        relay_r  <= relay_nxt;
        manual_r <= manual_nxt;
        held_r   <= held_nxt;
        shown_r  <= shown_nxt;
        splash_r <= splash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_buttons_r <= in_buttons;
    end
    if (advance) begin
      res_relay_r  <= relay_nxt;
      res_shown_r  <= shown_nxt;
      res_manual_r <= manual_nxt & relay_nxt;
      res_key_r    <= key_nxt;
    end
  end

endmodule

[sv/rctc_checker.sv]
// ----------------------------------------------------------------------------
// rctc_checker
// Port-level checks for the relay countdown timer controller.
// ----------------------------------------------------------------------------
module rctc_checker
  import rctc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [NUM_BUTTONS-1:0] in_buttons,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_relay_on,
  input logic [SEG_W-1:0]       out_seg_left,
  input logic [SEG_W-1:0]       out_seg_middle,
  input logic [SEG_W-1:0]       out_seg_right,
  input logic                   out_manual_active,
  input logic [KEY_W-1:0]       out_key_taken
);

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_taken <= KEY_MANUAL)
    else $error("key_taken out of range");

  a_manual_needs_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_manual_active |-> out_relay_on)
    else $error("manual mode without relay");

  a_preset_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_taken != KEY_NONE && out_key_taken != KEY_MANUAL
    |-> out_relay_on && !out_manual_active)
    else $error("preset key did not start countdown");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relay_on)
      && $stable(out_seg_left) && $stable(out_seg_middle)
      && $stable(out_seg_right) && $stable(out_key_taken))
    else $error("stalled result item changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_buttons))
    else $error("stalled input item changed");

endmodule

bind relay_countdown_timer_controller_core rctc_checker u_rctc_checker (.*);

[bench/relay_countdown_timer_controller_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relay_countdown_timer_controller_core_tb
// Self-checking bench for the relay countdown timer controller core.
// Ticks with button samples go in through the valid/ready input channel. A
// scoreboard predicts the relay, display and key result for each accepted
// tick and compares every result, field by field, in order. Runs a short
// directed sequence (splash, every key, manual start/stop, a full countdown
// to expiry), then random button traffic under several register settings
// with random stalls on both sides and a forced output back-pressure stretch.
// ----------------------------------------------------------------------------
module relay_countdown_timer_controller_core_tb;
  import rctc_pkg::*;

  typedef struct packed {
    logic             relay_on;
    logic [SEG_W-1:0] seg_left;
    logic [SEG_W-1:0] seg_middle;
    logic [SEG_W-1:0] seg_right;
    logic             manual_active;
    logic [KEY_W-1:0] key_taken;
  } tick_result_t;

  class tick_scoreboard;
    logic [CNT_W-1:0]       ticks_per_sec;
    logic [CNT_W-1:0]       splash_len;
    int unsigned            tick_count;
    int unsigned            seconds_left;
    int unsigned            splash_left;
    bit                     relay;
    bit                     manual;
    logic [NUM_BUTTONS-1:0] held;
    seg_disp_t              shown;
    tick_result_t           pending[$];
    int                     fails;
    int                     ticks;
    int                     checked;
    int                     writes;
    int                     expiries;

    function new();
      ticks_per_sec = TICKS_PER_SECOND_RST;
      splash_len    = SPLASH_TICKS_RST;
      tick_count    = 0;
      seconds_left  = 0;
      splash_left   = SPLASH_TICKS_RST;
      relay         = 1'b0;
      manual        = 1'b0;
      held          = '0;
      shown         = PAT_ON;
      fails         = 0;
      ticks         = 0;
      checked       = 0;
      writes        = 0;
      expiries      = 0;
    endfunction

    function logic [SEG_W-1:0] seg_of(int unsigned d);
      case (d)
        0: return 7'h3F;
        1: return 7'h06;
        2: return 7'h5B;
        3: return 7'h4F;
        4: return 7'h66;
        5: return 7'h6D;
        6: return 7'h7D;
        7: return 7'h07;
        8: return 7'h7F;
        default: return 7'h6F;
      endcase
    endfunction

    function seg_disp_t show_number(int unsigned v);
      seg_disp_t p;
      p.left   = seg_of((v / 100) % 10);
      p.middle = seg_of((v / 10) % 10);
      p.right  = seg_of(v % 10);
      return p;
    endfunction

    function int unsigned preset_minutes(int unsigned key);
      case (key)
        1: return 5;
        2: return 10;
        3: return 15;
        4: return 20;
        5: return 30;
        6: return 40;
        7: return 45;
        8: return 50;
        9: return 60;
        default: return 0;
      endcase
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CNT_W-1:0] v);
      writes++;
      if (idx == CFG_TICKS_PER_SECOND) begin
        ticks_per_sec = v;
      end else begin
        splash_len  = v;
        splash_left = v;
        shown       = (v != 0) ? PAT_ON : show_number(0);
      end
    endfunction

    function void note_tick(logic [NUM_BUTTONS-1:0] btn);
      int unsigned            t;
      int unsigned            key;
      int unsigned            mins;
      logic [NUM_BUTTONS-1:0] edges;
      tick_result_t           r;
      key = 0;
      ticks++;
      t = tick_count + 1;
      if (t >= ticks_per_sec) begin
        t = 0;
        if (seconds_left > 0) seconds_left--;
      end
      tick_count = t & 32'hFFFF;

      if (splash_left != 0) begin
        splash_left--;
        held = btn;
        if (splash_left == 0) shown = show_number(0);
      end else begin
        edges = btn & ~held;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (edges[i] && key == 0) begin
            key     = i + 1;
            held[i] = 1'b1;
          end
        end
        held &= btn;

        if (key == NUM_BUTTONS) begin
          seconds_left = 0;
          if (relay) begin
            relay  = 1'b0;
            manual = 1'b0;
            shown  = PAT_OFF;
          end else begin
            relay  = 1'b1;
            manual = 1'b1;
            shown  = PAT_ON;
          end
        end else if (key >= 1) begin
          mins         = preset_minutes(key);
          manual       = 1'b0;
          seconds_left = mins * 60;
          if (mins != 0) shown = show_number(mins);
          relay = 1'b1;
        end

        if (seconds_left > 0 && !manual) begin
          shown = show_number((seconds_left + 59) / 60);
        end else if (relay && !manual && seconds_left == 0) begin
          relay = 1'b0;
          shown = PAT_OFF;
          expiries++;
        end
      end

      r.relay_on      = relay;
      r.seg_left      = shown.left;
      r.seg_middle    = shown.middle;
      r.seg_right     = shown.right;
      r.manual_active = manual & relay;
      r.key_taken     = key[KEY_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (pending.size() == 0) begin
        $error("result item with no tick outstanding");
        fails++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.relay_on !== want.relay_on) begin
        $error("relay_on: expected %0d, actual %0d", want.relay_on, got.relay_on);
        fails++;
      end
      if (got.seg_left !== want.seg_left) begin
        $error("seg_left: expected 0x%02h, actual 0x%02h", want.seg_left, got.seg_left);
        fails++;
      end
      if (got.seg_middle !== want.seg_middle) begin
        $error("seg_middle: expected 0x%02h, actual 0x%02h", want.seg_middle, got.seg_middle);
        fails++;
      end
      if (got.seg_right !== want.seg_right) begin
        $error("seg_right: expected 0x%02h, actual 0x%02h", want.seg_right, got.seg_right);
        fails++;
      end
      if (got.manual_active !== want.manual_active) begin
        $error("manual_active: expected %0d, actual %0d", want.manual_active,
               got.manual_active);
        fails++;
      end
      if (got.key_taken !== want.key_taken) begin
        $error("key_taken: expected %0d, actual %0d", want.key_taken, got.key_taken);
        fails++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [NUM_BUTTONS-1:0] in_buttons = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_relay_on;
  logic [SEG_W-1:0]       out_seg_left;
  logic [SEG_W-1:0]       out_seg_middle;
  logic [SEG_W-1:0]       out_seg_right;
  logic                   out_manual_active;
  logic [KEY_W-1:0]       out_key_taken;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_TICKS_PER_SECOND;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  tick_scoreboard sb;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  bit             hold_request = 1'b0;

  relay_countdown_timer_controller_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_buttons        (in_buttons),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_relay_on      (out_relay_on),
    .out_seg_left      (out_seg_left),
    .out_seg_middle    (out_seg_middle),
    .out_seg_right     (out_seg_right),
    .out_manual_active (out_manual_active),
    .out_key_taken     (out_key_taken),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (48) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_tick({out_relay_on, out_seg_left, out_seg_middle, out_seg_right,
                     out_manual_active, out_key_taken});
  end

  task automatic send_tick(input logic [NUM_BUTTONS-1:0] btn);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_buttons <= btn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(btn);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly held buttons with occasional presses and releases
  function automatic logic [NUM_BUTTONS-1:0] next_buttons(logic [NUM_BUTTONS-1:0] cur);
    int r;
    r = $urandom_range(99);
    if (r < 65) return cur;
    if (r < 77) return '0;
    if (r < 87) return cur | (NUM_BUTTONS'(1) << $urandom_range(NUM_BUTTONS - 1));
    if (r < 93) return cur & ~(NUM_BUTTONS'(1) << $urandom_range(NUM_BUTTONS - 1));
    return NUM_BUTTONS'($urandom);
  endfunction

  initial begin
    logic [NUM_BUTTONS-1:0] cur_btn;
    int                     saved;
    sb = new();
    cur_btn = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // boot splash at reset values: keys ignored
    send_tick(10'h3FF);
    send_tick(10'h001);
    send_tick(10'h000);
    wait_drained();

    write_reg(CFG_SPLASH_TICKS, 16'd2);
    write_reg(CFG_TICKS_PER_SECOND, 16'd0);
    // manual key held through the splash is not taken afterwards
    repeat (3) send_tick(10'h200);
    send_tick(10'h000);
    send_tick(10'h200);
    send_tick(10'h201);
    send_tick(10'h000);
    // all pressed at once: one key per tick, lowest first, manual last stops
    repeat (10) send_tick(10'h3FF);
    send_tick(10'h000);
    send_tick(10'h200);
    send_tick(10'h000);
    send_tick(10'h200);
    wait_drained();

    // full countdown to expiry, one second per tick
    write_reg(CFG_SPLASH_TICKS, 16'd0);
    send_tick(10'h001);
    repeat (305) send_tick(10'h000);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 78;
          write_reg(CFG_TICKS_PER_SECOND, 16'd2);
          write_reg(CFG_SPLASH_TICKS, 16'd5);
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 29;
          write_reg(CFG_TICKS_PER_SECOND, 16'hFFFF);
          write_reg(CFG_SPLASH_TICKS, 16'd0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(CFG_TICKS_PER_SECOND, 16'($urandom_range(6, 1)));
          write_reg(CFG_SPLASH_TICKS, 16'd1);
        end
      endcase
      for (int i = 0; i < 80; i++) begin
        if (i == 40 && ph == 0) begin
          saved = tx_idle_pct;
          tx_idle_pct = 0;
          hold_request = 1'b1;
          repeat (30) begin
            cur_btn = next_buttons(cur_btn);
            send_tick(cur_btn);
          end
          tx_idle_pct = saved;
        end
        if (i == 40 && ph == 1) wait_drained();
        cur_btn = next_buttons(cur_btn);
        send_tick(cur_btn);
      end
      wait_drained();
    end

    // longest splash: display pinned to On, keys ignored
    write_reg(CFG_SPLASH_TICKS, 16'hFFFF);
    repeat (8) begin
      cur_btn = NUM_BUTTONS'($urandom);
      send_tick(cur_btn);
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.fails++;
    end

    $display("Covered %0d ticks: splash, every key, manual start/stop, expiry, %0d reg writes.",
             sb.ticks, sb.writes);
    $display("Checked %0d results, saw %0d countdown expiries.", sb.checked, sb.expiries);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rctc_pkg.sv
sv/relay_countdown_timer_controller_core.sv
sv/rctc_checker.sv
bench/relay_countdown_timer_controller_core_tb.sv
